// ----- design/sstat_pkg.sv -----
// Shared types and constants for the sample set statistics block.
package sstat_pkg;

  localparam int MAX_COUNT   = 1024;
  localparam int SAMPLE_W    = 16;
  localparam int CNT_W       = $clog2(MAX_COUNT + 1);
  localparam int SUM_W       = SAMPLE_W + CNT_W;
  localparam int SQ_W        = 2 * SAMPLE_W - 2 + CNT_W;
  localparam int PROD_W      = CNT_W + SQ_W;
  localparam int FRAC_W      = 16;
  localparam int DIV_W       = PROD_W + FRAC_W;
  localparam int DVSR_W      = 2 * CNT_W;
  localparam int REM_W       = DVSR_W + 1;
  localparam int STEP_W      = $clog2(DIV_W + 1);
  localparam int MEAN_W      = 32;
  localparam int VAR_W       = 47;
  localparam int COUNT_OUT_W = 11;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 128;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_SNAP,
    ST_MUL,
    ST_SUB,
    ST_DIVM,
    ST_DVLD,
    ST_DIVV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic acc_en;
    logic snap;
    logic mul;
    logic sub_load;
    logic div_step;
    logic var_load;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } status_t;

endpackage

// ----- design/sstat_ctrl.sv -----
// Controller state machine: accumulate, snapshot, multiply, subtract, two divisions, output.
module sstat_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tlast,
  output logic              s_tready,
  input  sstat_pkg::status_t status,
  output sstat_pkg::cmd_t    cmd
);
  import sstat_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = s_tvalid && (state == ST_ACC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACC;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACC:  if (accept && s_tlast) state_next = ST_SNAP;
      ST_SNAP: state_next = ST_MUL;
      ST_MUL:  state_next = ST_SUB;
      ST_SUB:  state_next = ST_DIVM;
      ST_DIVM: if (status.div_last) state_next = ST_DVLD;
      ST_DVLD: state_next = ST_DIVV;
      ST_DIVV: if (status.div_last) state_next = ST_OUT;
      ST_OUT:  if (status.out_free) state_next = ST_ACC;
      default: state_next = ST_ACC;
    endcase
  end

  always_comb begin
    cmd          = '0;
    s_tready     = 1'b0;
    unique case (state)
      ST_ACC: begin
        s_tready   = 1'b1;
        cmd.acc_en = accept;
      end
      ST_SNAP: cmd.snap     = 1'b1;
      ST_MUL:  cmd.mul      = 1'b1;
      ST_SUB:  cmd.sub_load = 1'b1;
      ST_DIVM: cmd.div_step = 1'b1;
      ST_DVLD: cmd.var_load = 1'b1;
      ST_DIVV: cmd.div_step = 1'b1;
      ST_OUT:  cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- design/sstat_dp.sv -----
// Datapath: accumulators, product registers, shared restoring divider, output register.
module sstat_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  sstat_pkg::cmd_t                        cmd,
  output sstat_pkg::status_t                     status,
  input  logic signed [sstat_pkg::SAMPLE_W-1:0]  sample,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic signed [sstat_pkg::SAMPLE_W-1:0]  maximum,
  output logic signed [sstat_pkg::SAMPLE_W-1:0]  minimum,
  output logic signed [sstat_pkg::MEAN_W-1:0]    mean_q16,
  output logic        [sstat_pkg::VAR_W-1:0]     variance_q16,
  output logic        [sstat_pkg::COUNT_OUT_W-1:0] sample_count,
  output logic                                   saturated
);
  import sstat_pkg::*;

  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  // running accumulators
  logic        [CNT_W-1:0]    count;
  logic signed [SAMPLE_W-1:0] run_max;
  logic signed [SAMPLE_W-1:0] run_min;
  logic signed [SUM_W-1:0]    run_sum;
  logic        [SQ_W-1:0]     run_sq;
  logic                       run_sat;
  logic signed [2*SAMPLE_W-1:0] sq_prod;

  // snapshot of a closed set
  logic        [CNT_W-1:0]    snap_n;
  logic signed [SAMPLE_W-1:0] snap_max;
  logic signed [SAMPLE_W-1:0] snap_min;
  logic                       snap_neg;
  logic        [SUM_W-1:0]    snap_smag;
  logic        [SQ_W-1:0]     snap_sq;
  logic                       snap_sat;

  logic [DVSR_W-1:0]   nn;
  logic [2*SUM_W-1:0]  ss;
  logic [PROD_W-1:0]   nq;
  logic [PROD_W-1:0]   diff;

  // divider
  logic [DIV_W-1:0]  quo;
  logic [REM_W-1:0]  rem;
  logic [DVSR_W-1:0] dvsr;
  logic [STEP_W-1:0] steps;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W:0]    trial;
  logic [MEAN_W-1:0] mq;
  logic [MEAN_W-1:0] mean_r;

  assign sq_prod = sample * sample;

  always_ff @(posedge clk) begin
    if (rst || cmd.snap) begin
      count   <= '0;
      run_max <= S_MIN;
      run_min <= S_MAX;
      run_sum <= '0;
      run_sq  <= '0;
      run_sat <= 1'b0;
    end else if (cmd.acc_en) begin
      if (count < CNT_W'(MAX_COUNT)) begin
        count   <= count + 1'b1;
        if (sample > run_max) run_max <= sample;
        if (sample < run_min) run_min <= sample;
        run_sum <= run_sum + SUM_W'(sample);
        run_sq  <= run_sq + SQ_W'($unsigned(sq_prod));
      end else begin
        run_sat <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      snap_n    <= count;
      snap_max  <= run_max;
      snap_min  <= run_min;
      snap_neg  <= run_sum[SUM_W-1];
      snap_smag <= run_sum[SUM_W-1] ? SUM_W'(-run_sum) : SUM_W'(run_sum);
      snap_sq   <= run_sq;
      snap_sat  <= run_sat;
    end
    if (cmd.mul) begin
      nn <= snap_n * snap_n;
      ss <= snap_smag * snap_smag;
      nq <= snap_n * snap_sq;
    end
    if (cmd.sub_load) begin
      diff <= nq - PROD_W'(ss);
    end
  end

  assign rem_sh = {rem[REM_W-2:0], quo[DIV_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (cmd.sub_load || cmd.var_load) begin
      steps <= STEP_W'(DIV_W);
    end else if (cmd.div_step) begin
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sub_load) begin
      quo  <= DIV_W'({snap_smag, {FRAC_W{1'b0}}});
      rem  <= '0;
      dvsr <= DVSR_W'(snap_n);
    end else if (cmd.var_load) begin
      quo  <= {diff, {FRAC_W{1'b0}}};
      rem  <= '0;
      dvsr <= nn;
    end else if (cmd.div_step) begin
      if (!trial[REM_W]) begin
        rem <= trial[REM_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign mq = quo[MEAN_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.var_load) begin
      mean_r <= snap_neg ? (-mq) : mq;
    end
  end

  assign status.div_last = (steps == STEP_W'(1));
  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      maximum      <= snap_max;
      minimum      <= snap_min;
      mean_q16     <= mean_r;
      variance_q16 <= quo[VAR_W-1:0];
      sample_count <= COUNT_OUT_W'(snap_n);
      saturated    <= snap_sat;
    end
  end

endmodule

// ----- design/sample_set_min_max_mean_variance.sv -----
// Top level: min, max, mean and population variance of a sample set.
// Throughput: one sample word per cycle while a set is open.
// After the closing word: snapshot, multiply, subtract, then the shared
// one-bit-per-cycle divider runs the mean then the variance before output.
// Input is held off from the closing word until the result enters the output register.
// Synchronous active-high reset clears the accumulators and the output valid.
module sample_set_min_max_mean_variance (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [sstat_pkg::IN_TDATA_W-1:0]   s_tdata,  // [15:0] sample
  input  logic                               s_tlast,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [15:0] maximum, [31:16] minimum, [63:32] mean_q16, [110:64] variance_q16,
  // [121:111] sample_count, [122] saturated, [127:123] zero
  output logic [sstat_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import sstat_pkg::*;

  cmd_t    cmd;
  status_t status;

  logic signed [SAMPLE_W-1:0]  maximum;
  logic signed [SAMPLE_W-1:0]  minimum;
  logic signed [MEAN_W-1:0]    mean_q16;
  logic        [VAR_W-1:0]     variance_q16;
  logic        [COUNT_OUT_W-1:0] sample_count;
  logic                        saturated;

  sstat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sstat_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample       ($signed(s_tdata[SAMPLE_W-1:0])),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .maximum      (maximum),
    .minimum      (minimum),
    .mean_q16     (mean_q16),
    .variance_q16 (variance_q16),
    .sample_count (sample_count),
    .saturated    (saturated)
  );

  assign m_tdata = {5'b0, saturated, sample_count, variance_q16,
                    mean_q16, minimum, maximum};

endmodule
